// ----- src/multipath_next_hop_table_unit_assert.svh -----
// Assertion macros for the multipath next hop table unit.
// Expects signals named clock and reset in the including scope.
`ifndef MULTIPATH_NEXT_HOP_TABLE_UNIT_ASSERT_SVH
`define MULTIPATH_NEXT_HOP_TABLE_UNIT_ASSERT_SVH

// checked outside reset
`define MNHT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define MNHT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/mnht_pkg.sv -----
// Shared types for the multipath next hop table unit.
// No dependencies.
package mnht_pkg;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_ROTATE = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [31:0] next_hop;
      logic [15:0] hop_count;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        found;
      logic [1:0]  found_slot;
      logic [2:0]  table_count;
      logic [2:0]  current_slot;
      logic [31:0] current_next_hop;
      logic [15:0] current_hops;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic execute;
   } cmd_type;

endpackage

// ----- src/mnht_datapath.sv -----
// Datapath: route table, count, round-robin pointer, result fields.
// Depends on mnht_pkg.
module mnht_datapath #(
   parameter int MAX_ROUTES = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  mnht_pkg::cmd_type cmd,
   input  mnht_pkg::req_type req_data,
   output mnht_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
   localparam int CNT_W = $clog2(MAX_ROUTES + 1);
   localparam int SW    = (IDX_W > 2) ? IDX_W : 2;
   localparam int CW    = (CNT_W > 3) ? CNT_W : 3;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ROUTES);

   mnht_pkg::req_type req_ff;

   logic [31:0]      addr_ff [MAX_ROUTES];
   logic [15:0]      hops_ff [MAX_ROUTES];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] ptr_ff;
   logic             accepted_ff;
   logic             found_ff;
   logic [IDX_W-1:0] slot_ff;

   logic             hit;
   logic [IDX_W-1:0] slot;
   logic             add_ok;
   logic             del_ok;
   logic [CNT_W-1:0] count_dec;
   logic [CNT_W:0]   ptr_inc;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] ptr_in;
   logic             accepted_in;

   always_comb begin
      hit  = 1'b0;
      slot = '0;
      for (int i = 0; i < MAX_ROUTES; i++) begin
         if ((CNT_W'(i) < count_ff) && (addr_ff[i] == req_ff.next_hop)) begin
            hit  = 1'b1;
            slot = IDX_W'(i);
         end
      end
   end

   always_comb begin
      add_ok      = (req_ff.operation == mnht_pkg::OP_ADD) && (count_ff < MAX_CNT) && !hit;
      del_ok      = (req_ff.operation == mnht_pkg::OP_DELETE) && hit;
      count_dec   = count_ff - CNT_W'(1);
      ptr_inc     = {1'b0, ptr_ff} + (CNT_W + 1)'(1);
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      accepted_in = 1'b0;
      unique case (req_ff.operation)
         mnht_pkg::OP_ADD: begin
            accepted_in = add_ok;
            if (add_ok) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         mnht_pkg::OP_DELETE: begin
            accepted_in = del_ok;
            if (del_ok) begin
               count_in = count_dec;
               if (ptr_ff > count_dec) begin
                  ptr_in = count_dec;
               end
            end
         end
         mnht_pkg::OP_ROTATE: begin
            accepted_in = 1'b1;
            ptr_in = (ptr_inc >= {1'b0, count_ff}) ? '0 : ptr_inc[CNT_W-1:0];
         end
         default: begin
            accepted_in = hit;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.execute) begin
         accepted_ff <= accepted_in;
         found_ff    <= hit;
         slot_ff     <= slot;
         for (int i = 0; i < MAX_ROUTES; i++) begin
            if (add_ok && (count_ff == CNT_W'(i))) begin
               addr_ff[i] <= req_ff.next_hop;
               hops_ff[i] <= req_ff.hop_count;
            end
         end
         for (int i = 0; i < MAX_ROUTES - 1; i++) begin
            if (del_ok && (IDX_W'(i) >= slot)) begin
               addr_ff[i] <= addr_ff[i+1];
               hops_ff[i] <= hops_ff[i+1];
            end
         end
      end
   end

   logic [SW-1:0]    slot_wide;
   logic [CW-1:0]    count_wide;
   logic [CW-1:0]    ptr_wide;
   logic             ptr_valid;
   logic [IDX_W-1:0] ptr_idx;

   always_comb begin
      slot_wide  = SW'(slot_ff);
      count_wide = CW'(count_ff);
      ptr_wide   = CW'(ptr_ff);
      ptr_valid  = ptr_ff < count_ff;
      ptr_idx    = ptr_ff[IDX_W-1:0];

      rsp_data.accepted     = accepted_ff;
      rsp_data.found        = found_ff;
      rsp_data.found_slot   = slot_wide[1:0];
      rsp_data.table_count  = count_wide[2:0];
      rsp_data.current_slot = ptr_wide[2:0];
      if (ptr_valid) begin
         rsp_data.current_next_hop = addr_ff[ptr_idx];
         rsp_data.current_hops     = hops_ff[ptr_idx];
      end else begin
         rsp_data.current_next_hop = '0;
         rsp_data.current_hops     = '0;
      end
   end

endmodule

// ----- src/mnht_ctrl.sv -----
// Controller: sequences capture, execute and response beat.
// Depends on mnht_pkg.
module mnht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output mnht_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      take;

   assign take        = start && !busy_ff;
   assign busy        = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.load    = take;
   assign cmd.execute = (state_ff == ST_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE, ST_RESP: begin
               rsp_valid_ff <= 1'b0;
               if (take) begin
                  state_ff <= ST_EXEC;
                  busy_ff  <= 1'b1;
               end else begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_EXEC: begin
               state_ff     <= ST_RESP;
               busy_ff      <= 1'b0;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff     <= ST_IDLE;
               busy_ff      <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

// ----- src/multipath_next_hop_table_unit.sv -----
// Top level of the multipath next hop table unit.
// Depends on mnht_pkg, mnht_ctrl and mnht_datapath.
//
// Usage:
//   Request channel: drive req_data and raise start; the beat is taken at
//   a rising edge where start is high and busy is low.
//   Response channel: rsp_valid is high for exactly one cycle and rsp_data
//   holds the result during that cycle. The receiver cannot stall.
// Sequence: after the request edge the controller enters the execute state,
//   which compares and updates the table; rsp_valid is registered as it
//   moves to the response state, where the receiver takes the beat.
// Pacing: busy is high only in the execute cycle, and a new request may be
//   taken in the response cycle. The controller has a single execute step.
// Reset (synchronous, active high): route count and pointer go to zero,
//   the controller returns to idle and no response is pending. Table
//   entries are not cleared; slots at or above the count are never shown.
// Delete shifts later entries down; all live slots are compared against
//   next_hop in parallel on every operation.
module multipath_next_hop_table_unit #(
   parameter int MAX_ROUTES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mnht_pkg::req_type req_data,
   output logic              rsp_valid,
   output mnht_pkg::rsp_type rsp_data
);

   mnht_pkg::cmd_type cmd;

   mnht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   mnht_datapath #(
      .MAX_ROUTES (MAX_ROUTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ----- src/mnht_checker.sv -----
// Port-level checks for the multipath next hop table unit, bound to the top.
// Depends on mnht_pkg and multipath_next_hop_table_unit_assert.svh.
`include "multipath_next_hop_table_unit_assert.svh"

module mnht_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input mnht_pkg::req_type req_data,
   input logic              rsp_valid,
   input mnht_pkg::rsp_type rsp_data
);

   `MNHT_ASSERT_ALWAYS(a_reset_idle, reset |=> (!busy && !rsp_valid), "not idle after reset")
   `MNHT_ASSERT(a_take_busy, (start && !busy) |=> (busy && !rsp_valid), "beat not executing")
   `MNHT_ASSERT(a_busy_resp, busy |=> (!busy && rsp_valid), "no response after execute")
   `MNHT_ASSERT(a_rotate_ok, (start && !busy && req_data.operation == mnht_pkg::OP_ROTATE) |=> ##1 (rsp_valid && rsp_data.accepted), "rotate not accepted")
   `MNHT_ASSERT(a_miss_slot, (rsp_valid && !rsp_data.found) |-> (rsp_data.found_slot == 2'd0), "slot set on miss")

endmodule

bind multipath_next_hop_table_unit mnht_checker u_mnht_checker (.*);

// ----- bench/mnht_route_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the multipath next hop table unit: mirrors the route table,
// predicts each result beat and compares it field by field. Uses mnht_pkg.
module mnht_route_checker
   import mnht_pkg::*;
#(
   parameter int ROUTE_SLOTS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      outstanding
);

   logic [31:0] hop_addr [ROUTE_SLOTS];
   logic [15:0] hop_cost [ROUTE_SLOTS];
   int unsigned route_total;
   int unsigned rr_pointer;
   rsp_type     expected_routes [$];

   // Applies one request to the mirrored table and returns the route report.
   function automatic rsp_type next_route_report(input req_type beat);
      rsp_type     r;
      logic        hit;
      int unsigned slot;
      int unsigned i;
      hit = 1'b0;
      slot = 0;
      r = '0;
      for (i = 0; i < route_total; i++) begin
         if (hop_addr[i] == beat.next_hop) begin
            hit = 1'b1;
            slot = i;
         end
      end
      case (beat.operation)
         OP_ADD: begin
            if (route_total < ROUTE_SLOTS && !hit) begin
               hop_addr[route_total] = beat.next_hop;
               hop_cost[route_total] = beat.hop_count;
               route_total++;
               r.accepted = 1'b1;
            end
         end
         OP_DELETE: begin
            if (hit) begin
               for (i = slot + 1; i < ROUTE_SLOTS; i++) begin
                  hop_addr[i - 1] = hop_addr[i];
                  hop_cost[i - 1] = hop_cost[i];
               end
               route_total--;
               if (rr_pointer > route_total) rr_pointer = route_total;
               r.accepted = 1'b1;
            end
         end
         OP_ROTATE: begin
            rr_pointer++;
            if (rr_pointer >= route_total) rr_pointer = 0;
            r.accepted = 1'b1;
         end
         default: r.accepted = hit;
      endcase
      r.found = hit;
      r.found_slot = 2'(slot);
      r.table_count = 3'(route_total);
      r.current_slot = 3'(rr_pointer);
      if (rr_pointer < route_total) begin
         r.current_next_hop = hop_addr[rr_pointer];
         r.current_hops = hop_cost[rr_pointer];
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want_v, got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", field, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         route_total = 0;
         rr_pointer = 0;
         for (int i = 0; i < ROUTE_SLOTS; i++) begin
            hop_addr[i] = '0;
            hop_cost[i] = '0;
         end
         expected_routes.delete();
      end else begin
         // result beat belongs to an earlier request; retire it first
         if (rsp_valid === 1'b1) begin
            if (expected_routes.size() == 0) begin
               $error("result beat with nothing expected: %p", rsp_data);
               mismatch_count++;
            end else begin
               want = expected_routes.pop_front();
               check_field("accepted", want.accepted, rsp_data.accepted);
               check_field("found", want.found, rsp_data.found);
               check_field("found_slot", want.found_slot, rsp_data.found_slot);
               check_field("table_count", want.table_count, rsp_data.table_count);
               check_field("current_slot", want.current_slot, rsp_data.current_slot);
               check_field("current_next_hop", want.current_next_hop,
                           rsp_data.current_next_hop);
               check_field("current_hops", want.current_hops, rsp_data.current_hops);
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            expected_routes.push_back(next_route_report(req_data));
      end
      outstanding = expected_routes.size();
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top of the multipath next hop table bench: clock, reset, directed and random
// request beats with idle bursts. Needs mnht_pkg, the unit and mnht_route_checker.
module testbench;
   import mnht_pkg::*;

   localparam int ROUTE_SLOTS = 4;
   localparam int RANDOM_BEATS = 1400;
   localparam int CALM_TAIL = 150;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      mismatch_count;
   int      outstanding;

   multipath_next_hop_table_unit #(
      .MAX_ROUTES(ROUTE_SLOTS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   mnht_route_checker #(
      .ROUTE_SLOTS(ROUTE_SLOTS)
   ) route_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic req_type make_beat(input op_type op, input logic [31:0] hop,
                                         input logic [15:0] cost);
      req_type b;
      b.operation = op;
      b.next_hop = hop;
      b.hop_count = cost;
      return b;
   endfunction

   // holds start high until the beat is taken
   task automatic send_beat(input req_type beat);
      req_data <= beat;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic idle_gap(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      logic [31:0] hop_pool [8];
      logic [31:0] hop_a;
      logic [31:0] hop_b;
      logic [31:0] hop;
      op_type      op;
      int          add_pct;
      int          gap_pct;
      int          roll;

      hop_a = 32'hA5A5_0001;
      hop_b = 32'h5A5A_F00E;
      hop_pool[0] = 32'h0000_0000;
      hop_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) hop_pool[i] = $urandom;
      add_pct = 35;
      gap_pct = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table
      send_beat(make_beat(OP_ROTATE, 32'hFFFF_FFFF, 16'hFFFF));
      send_beat(make_beat(OP_LOOKUP, 32'h0000_0000, 16'h0000));
      send_beat(make_beat(OP_DELETE, hop_a, 16'h0001));
      // fill, duplicate and full
      send_beat(make_beat(OP_ADD, 32'h0000_0000, 16'h0000));
      send_beat(make_beat(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF));
      send_beat(make_beat(OP_ADD, 32'h0000_0000, 16'h1234));
      send_beat(make_beat(OP_ADD, hop_a, 16'h0005));
      send_beat(make_beat(OP_ADD, hop_b, 16'h0007));
      send_beat(make_beat(OP_ADD, 32'h1357_9BDF, 16'h0009));
      send_beat(make_beat(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF));
      send_beat(make_beat(OP_LOOKUP, 32'h1357_9BDF, 16'h0000));
      // walk pointer to last slot, then delete it so pointer lands on count
      send_beat(make_beat(OP_ROTATE, hop_a, 16'h0000));
      send_beat(make_beat(OP_ROTATE, 32'h0000_0000, 16'h0000));
      send_beat(make_beat(OP_ROTATE, hop_b, 16'h0000));
      send_beat(make_beat(OP_DELETE, hop_b, 16'hFFFF));
      send_beat(make_beat(OP_ROTATE, 32'h0000_0000, 16'h0000));
      // delete head with shift, absent delete
      send_beat(make_beat(OP_DELETE, 32'h0000_0000, 16'h0000));
      send_beat(make_beat(OP_DELETE, hop_b, 16'h0000));
      send_beat(make_beat(OP_LOOKUP, hop_a, 16'h0000));
      send_beat(make_beat(OP_ROTATE, hop_a, 16'h0000));
      send_beat(make_beat(OP_ROTATE, hop_a, 16'h0000));
      send_beat(make_beat(OP_DELETE, hop_a, 16'h0000));
      send_beat(make_beat(OP_DELETE, 32'hFFFF_FFFF, 16'h0000));
      send_beat(make_beat(OP_ROTATE, 32'hFFFF_FFFF, 16'h0000));

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 64 == 0) begin
            add_pct = $urandom_range(15, 55);
            gap_pct = ((n / 64) % 3 == 2) ? 0 : $urandom_range(10, 40);
         end
         roll = $urandom_range(0, 99);
         if (roll < add_pct) op = OP_ADD;
         else if (roll < add_pct + 25) op = OP_DELETE;
         else if (roll < add_pct + 45) op = OP_ROTATE;
         else op = OP_LOOKUP;
         hop = ($urandom_range(0, 99) < 85) ? hop_pool[$urandom_range(0, 7)] : $urandom;
         send_beat(make_beat(op, hop, 16'($urandom)));
         if (n < RANDOM_BEATS - CALM_TAIL && $urandom_range(0, 99) < gap_pct)
            idle_gap($urandom_range(1, 19));
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      if (mismatch_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/mnht_pkg.sv
src/mnht_datapath.sv
src/mnht_ctrl.sv
src/multipath_next_hop_table_unit.sv
src/mnht_checker.sv
bench/mnht_route_checker.sv
bench/testbench.sv
